@@ rtl/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants for the track event parser
// Result kinds, register indexes, parse phases, the result record, the name pattern and the chunk tag.
// ----------------------------------------------------------------------------
`default_nettype none
package smf_pkg;

    localparam int NAME_LIMIT = 255;
    localparam int PAT_LEN    = 11;

    typedef enum logic [2:0] {
        KIND_DIVISION = 3'd0,
        KIND_TEMPO    = 3'd1,
        KIND_NOTE_ON  = 3'd2,
        KIND_NOTE_OFF = 3'd3,
        KIND_TRACK    = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    typedef enum logic [13:0] {
        P_HEAD      = 14'b00000000000001,
        P_TAG       = 14'b00000000000010,
        P_LEN       = 14'b00000000000100,
        P_DELTA     = 14'b00000000001000,
        P_STATUS    = 14'b00000000010000,
        P_DATA1     = 14'b00000000100000,
        P_DATA2     = 14'b00000001000000,
        P_META_TYPE = 14'b00000010000000,
        P_META_LEN  = 14'b00000100000000,
        P_SYSEX_LEN = 14'b00001000000000,
        P_NAME      = 14'b00010000000000,
        P_TEMPO     = 14'b00100000000000,
        P_SKIP      = 14'b01000000000000,
        P_DONE      = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] tick;
        logic [23:0] value;
        logic        guitar;
    } result_t;

    function automatic logic [7:0] pattern_byte(input logic [3:0] pos);
        case (pos)
            4'd0:    pattern_byte = 8'h50;
            4'd1:    pattern_byte = 8'h41;
            4'd2:    pattern_byte = 8'h52;
            4'd3:    pattern_byte = 8'h54;
            4'd4:    pattern_byte = 8'h20;
            4'd5:    pattern_byte = 8'h47;
            4'd6:    pattern_byte = 8'h55;
            4'd7:    pattern_byte = 8'h49;
            4'd8:    pattern_byte = 8'h54;
            4'd9:    pattern_byte = 8'h41;
            4'd10:   pattern_byte = 8'h52;
            default: pattern_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tag_byte(input logic [1:0] pos);
        case (pos)
            2'd0:    tag_byte = 8'h4D;
            2'd1:    tag_byte = 8'h54;
            2'd2:    tag_byte = 8'h72;
            default: tag_byte = 8'h6B;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/smf_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// smf_track_event_parser: Standard MIDI File track event parser
// Byte-wide parser reporting division, tempo, note, track-end and error records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: data_byte plus start_of_file, transfer on valid && !stall.
//   start_of_file restarts the parser with that byte as file byte 0.
//   Output channel: kind/tick/value/guitar_track/last_of_run, transfer on
//   out_valid && !out_stall. A byte yields zero, one or two records; the
//   last record of a byte has last_of_run set.
//   Config channel: cfg_valid/cfg_ready, cfg_index 0 lowest_note,
//   1 highest_note. Writes are taken in any cycle.
//   Timing: a byte is parsed in the cycle after its transfer into the input
//   register and its records load the output register at the next edge. One
//   byte per cycle is sustained while results advance; a byte that yields
//   two records holds the input while the second drains.
//   Stall: the input register stalls while the output is stalled or a record is pending.
//   Reset: phase returns to header skip, note range to 84..88, no records.
// ----------------------------------------------------------------------------
`default_nettype none
module smf_track_event_parser
    import smf_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    input  wire         start_of_file,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  kind,
    output logic [31:0] tick,
    output logic [23:0] value,
    output logic        guitar_track,
    output logic        last_of_run,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [6:0]  cfg_data
);

    // configuration
    logic [6:0] lowest_reg, highest_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lowest_reg  <= 7'd84;
            highest_reg <= 7'd88;
        end else if (cfg_valid) begin
            if (cfg_index == REG_LOWEST) lowest_reg <= cfg_data;
            else highest_reg <= cfg_data;
        end
    end

    // input register
    logic       iv_reg;
    logic [7:0] ib_reg;
    logic       is_reg;
    logic       advance;
    assign in_stall = iv_reg && !advance;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            iv_reg <= 1'b0;
        end else if (!in_stall) begin
            iv_reg <= in_valid;
        end
    end
    always_ff @(posedge clk) begin
        if (!in_stall && in_valid) begin
            ib_reg <= data_byte;
            is_reg <= start_of_file;
        end
    end

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  pbc_reg, pbc_next;
    logic [31:0] tbl_reg, tbl_next;
    logic [15:0] tl_reg, tl_next, tn_reg, tn_next;
    logic [7:0]  rs_reg, rs_next, cs_reg, cs_next;
    logic [31:0] at_reg, at_next, va_reg, va_next;
    logic [7:0]  mk_reg, mk_next;
    logic [31:0] sk_reg, sk_next;
    logic [7:0]  fd_reg, fd_next;
    logic [23:0] ta_reg, ta_next;
    logic [3:0]  nm_reg, nm_next;
    logic        ne_reg, ne_next, gs_reg, gs_next, h_reg, h_next;

    result_t r0, r1;
    logic [1:0] cnt;

    always_comb begin
        logic [7:0]  b;
        logic [31:0] vl;
        logic        vdone;
        logic [7:0]  ty;
        b = ib_reg;
        phase_next = phase_reg; pbc_next = pbc_reg; tbl_next = tbl_reg;
        tl_next = tl_reg; tn_next = tn_reg; rs_next = rs_reg; cs_next = cs_reg;
        at_next = at_reg; va_next = va_reg; mk_next = mk_reg; sk_next = sk_reg;
        fd_next = fd_reg; ta_next = ta_reg; nm_next = nm_reg; ne_next = ne_reg;
        gs_next = gs_reg; h_next = h_reg;
        cnt = 2'd0;
        r0 = '0; r1 = '0;
        if (is_reg) begin
            phase_next = P_HEAD; pbc_next = '0; tbl_next = '0; tl_next = '0;
            tn_next = '0; rs_next = '0; cs_next = '0; at_next = '0; va_next = '0;
            mk_next = '0; sk_next = '0; fd_next = '0; ta_next = '0; nm_next = '0;
            ne_next = 1'b0; gs_next = 1'b0; h_next = 1'b0;
        end
        vl = {va_next[24:0], b[6:0]};
        vdone = !b[7];
        ty = {cs_next[7:4], 4'h0};
        if (!h_next) begin
            case (phase_next)
                P_HEAD: begin
                    if (pbc_next == 4'd10 || pbc_next == 4'd11) begin
                        tl_next = {tl_next[7:0], b};
                        pbc_next = pbc_next + 4'd1;
                    end else if (pbc_next == 4'd12) begin
                        va_next = {24'd0, b};
                        pbc_next = pbc_next + 4'd1;
                    end else if (pbc_next == 4'd13) begin
                        r0 = '{KIND_DIVISION, 32'd0, {8'd0, va_next[7:0], b}, 1'b0};
                        cnt = 2'd1;
                        va_next = '0;
                        if (tl_next == 16'd0) phase_next = P_DONE;
                        else begin
                            phase_next = P_TAG; pbc_next = '0; at_next = '0;
                            rs_next = '0; gs_next = 1'b0;
                        end
                    end else pbc_next = pbc_next + 4'd1;
                end
                P_TAG: begin
                    if (b != tag_byte(pbc_next[1:0])) begin
                        r0 = '{KIND_ERROR, at_next, {8'd0, tn_next}, 1'b0};
                        cnt = 2'd1; h_next = 1'b1;
                    end else begin
                        pbc_next = pbc_next + 4'd1;
                        if (pbc_next >= 4'd4) begin
                            phase_next = P_LEN; pbc_next = '0; tbl_next = '0;
                        end
                    end
                end
                P_LEN: begin
                    tbl_next = {tbl_next[23:0], b};
                    pbc_next = pbc_next + 4'd1;
                    if (pbc_next >= 4'd4) begin
                        at_next = '0; rs_next = '0; gs_next = 1'b0;
                        phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                        if (tbl_next == 32'd0) begin
                            r0 = '{KIND_TRACK, 32'd0, {8'd0, tn_next}, 1'b0};
                            cnt = 2'd1;
                            tn_next = tn_next + 16'd1; tl_next = tl_next - 16'd1;
                            if (tl_next == 16'd0) phase_next = P_DONE;
                            else begin
                                phase_next = P_TAG; pbc_next = '0;
                            end
                        end
                    end
                end
                P_DONE: ;
                default: begin
                    tbl_next = tbl_next - 32'd1;
                    case (phase_next)
                        P_DELTA: begin
                            va_next = vl;
                            if (pbc_next < 4'd15) pbc_next = pbc_next + 4'd1;
                            if (vdone) begin
                                at_next = at_next + vl; va_next = '0;
                                pbc_next = '0; phase_next = P_STATUS;
                            end
                        end
                        P_STATUS, P_DATA1: begin
                            if (phase_next == P_STATUS && b[7]) begin
                                cs_next = b;
                                rs_next = (b >= 8'hF0) ? 8'h00 : b;
                                if (b == 8'hFF) phase_next = P_META_TYPE;
                                else if (b == 8'hF0 || b == 8'hF7) begin
                                    phase_next = P_SYSEX_LEN; va_next = '0; pbc_next = '0;
                                end else phase_next = P_DATA1;
                            end else begin
                                if (phase_next == P_STATUS) cs_next = rs_next;
                                ty = {cs_next[7:4], 4'h0};
                                fd_next = b;
                                if (ty == 8'hC0 || ty == 8'hD0) begin
                                    phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                                end else phase_next = P_DATA2;
                            end
                        end
                        P_DATA2: begin
                            if ((ty == 8'h90 || ty == 8'h80) &&
                                fd_next >= {1'b0, lowest_reg} &&
                                fd_next <= {1'b0, highest_reg}) begin
                                r0 = '{((ty == 8'h90 && b != 8'd0) ? KIND_NOTE_ON
                                        : KIND_NOTE_OFF), at_next,
                                       {16'd0, fd_next}, 1'b0};
                                cnt = 2'd1;
                            end
                            phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                        end
                        P_META_TYPE: begin
                            mk_next = b; phase_next = P_META_LEN;
                            va_next = '0; pbc_next = '0;
                        end
                        P_META_LEN, P_SYSEX_LEN: begin
                            va_next = vl;
                            if (pbc_next < 4'd15) pbc_next = pbc_next + 4'd1;
                            if (vdone) begin
                                va_next = '0; pbc_next = '0;
                                if (phase_next == P_META_LEN && mk_next == 8'h03 &&
                                    vl < 32'(NAME_LIMIT)) begin
                                    if (vl == 32'd0) phase_next = P_DELTA;
                                    else begin
                                        sk_next = vl; nm_next = '0; ne_next = 1'b0;
                                        phase_next = P_NAME;
                                    end
                                end else if (phase_next == P_META_LEN &&
                                             mk_next == 8'h51 && vl == 32'd3) begin
                                    ta_next = '0; phase_next = P_TEMPO;
                                end else if (vl == 32'd0) phase_next = P_DELTA;
                                else begin
                                    sk_next = vl; phase_next = P_SKIP;
                                end
                            end
                        end
                        P_NAME: begin
                            if (!ne_next) begin
                                if (b == 8'd0) ne_next = 1'b1;
                                else if (nm_next < 4'(PAT_LEN) &&
                                         b == pattern_byte(nm_next)) begin
                                    nm_next = nm_next + 4'd1;
                                    if (nm_next >= 4'(PAT_LEN)) begin
                                        gs_next = 1'b1; nm_next = '0;
                                    end
                                end else nm_next = (b == pattern_byte(4'd0)) ? 4'd1 : 4'd0;
                            end
                            sk_next = sk_next - 32'd1;
                            if (sk_next == 32'd0) begin
                                phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                            end
                        end
                        P_TEMPO: begin
                            ta_next = {ta_next[15:0], b};
                            pbc_next = pbc_next + 4'd1;
                            if (pbc_next >= 4'd3) begin
                                r0 = '{KIND_TEMPO, at_next, ta_next, 1'b0};
                                cnt = 2'd1;
                                phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                            end
                        end
                        default: begin
                            sk_next = sk_next - 32'd1;
                            if (sk_next == 32'd0) begin
                                phase_next = P_DELTA; pbc_next = '0; va_next = '0;
                            end
                        end
                    endcase
                    // end of track bytes
                    if (tbl_next == 32'd0) begin
                        if (phase_next == P_DELTA && pbc_next == 4'd0) begin
                            r1 = '{KIND_TRACK, at_next, {8'd0, tn_next}, gs_next};
                            tn_next = tn_next + 16'd1; tl_next = tl_next - 16'd1;
                            if (tl_next == 16'd0) phase_next = P_DONE;
                            else begin
                                phase_next = P_TAG; pbc_next = '0; at_next = '0;
                                rs_next = '0; gs_next = 1'b0;
                            end
                        end else begin
                            r1 = '{KIND_ERROR, at_next, {8'd0, tn_next}, 1'b0};
                            h_next = 1'b1;
                        end
                        if (cnt == 2'd0) begin
                            r0 = r1; cnt = 2'd1;
                        end else cnt = 2'd2;
                    end
                end
            endcase
        end
    end

    // output register with one pending second record
    logic    ov_reg, ol_reg, pend_reg;
    result_t ores_reg, pres_reg;
    logic    out_free;
    assign out_free = !ov_reg || !out_stall;
    // a byte may commit when the output can take its first record and
    // nothing is pending
    assign advance = out_free && !pend_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            ores_reg  <= '0;
            pres_reg  <= '0;
            phase_reg <= P_HEAD;
            pbc_reg <= '0; tbl_reg <= '0; tl_reg <= '0; tn_reg <= '0;
            rs_reg <= '0; cs_reg <= '0; at_reg <= '0; va_reg <= '0;
            mk_reg <= '0; sk_reg <= '0; fd_reg <= '0; ta_reg <= '0;
            nm_reg <= '0; ne_reg <= 1'b0; gs_reg <= 1'b0; h_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (pend_reg) begin
                    ov_reg <= 1'b1; ol_reg <= 1'b1; ores_reg <= pres_reg;
                    pend_reg <= 1'b0;
                end else if (iv_reg && cnt != 2'd0) begin
                    ov_reg <= 1'b1; ol_reg <= (cnt == 2'd1); ores_reg <= r0;
                    pend_reg <= (cnt == 2'd2); pres_reg <= r1;
                end else ov_reg <= 1'b0;
            end
            if (iv_reg && advance) begin
                phase_reg <= phase_next; pbc_reg <= pbc_next; tbl_reg <= tbl_next;
                tl_reg <= tl_next; tn_reg <= tn_next; rs_reg <= rs_next;
                cs_reg <= cs_next; at_reg <= at_next; va_reg <= va_next;
                mk_reg <= mk_next; sk_reg <= sk_next; fd_reg <= fd_next;
                ta_reg <= ta_next; nm_reg <= nm_next; ne_reg <= ne_next;
                gs_reg <= gs_next; h_reg <= h_next;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign kind         = ores_reg.kind;
    assign tick         = ores_reg.tick;
    assign value        = ores_reg.value;
    assign guitar_track = ores_reg.guitar;
    assign last_of_run  = ol_reg;

endmodule
`default_nettype wire

@@ rtl/smf_checker.sv @@
// ----------------------------------------------------------------------------
// smf_checker: port-level checks for the track event parser
// Watches records on the output channel and the input handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module smf_checker
    import smf_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [2:0]  kind,
    input wire [31:0] tick,
    input wire [23:0] value,
    input wire        guitar_track,
    input wire        last_of_run
);

    // a stalled input transfer stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input withdrawn under stall");

    // a stalled record holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value))
        else $error("stalled record changed");

    // only track end records carry the guitar flag
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && guitar_track |-> kind == KIND_TRACK)
        else $error("guitar flag on wrong kind");

    // division records have zero tick and are last of their run
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DIVISION |-> tick == 32'd0 && last_of_run)
        else $error("bad division record");

    // a record that is not last of its run is a note or tempo record
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF ||
        kind == KIND_TEMPO)
        else $error("unexpected first record");

endmodule

bind smf_track_event_parser smf_checker u_smf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .tick(tick),
    .value(value), .guitar_track(guitar_track), .last_of_run(last_of_run)
);
`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for smf_track_event_parser
// Feeds generated MIDI files, some well formed and some broken, one byte per
// transfer, and predicts every record. Runs through several note ranges, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench
    import smf_pkg::*;
();

    // MIDI codes used by the predictor and the file generator
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_PRESSURE  = 8'hD0;
    localparam logic [7:0] META_NAME    = 8'h03;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam string      GUITAR_TXT   = "PART GUITAR";
    localparam string      CHUNK_TXT    = "MTrk";
    localparam int         DRAIN_CYCLES = 10;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] tick;
        logic [23:0] value;
        logic        guitar;
        logic        last;
    } rec_t;

    typedef struct {
        logic [7:0] b;
        logic       sof;
    } file_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        start_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [23:0] value;
    logic        guitar_track;
    logic        last_of_run;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_LOWEST;
    logic [6:0]  cfg_data = 7'd0;

    smf_track_event_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .start_of_file(start_of_file),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .tick(tick), .value(value),
        .guitar_track(guitar_track), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser predictor state
    // ------------------------------------------------------------------
    logic [6:0]  lo_note = 7'd84, hi_note = 7'd88;
    phase_t      ph = P_HEAD;
    logic [3:0]  pbc = '0;
    logic [31:0] bytes_left = '0;
    logic [15:0] tracks_left = '0, track_idx = '0;
    logic [7:0]  run_st = '0, cur_st = '0;
    logic [31:0] abs_tick = '0, vacc = '0;
    logic [7:0]  meta_id = '0;
    logic [31:0] skip_left = '0;
    logic [7:0]  first_db = '0;
    logic [23:0] tempo_acc = '0;
    logic [3:0]  match_pos = '0;
    logic        name_stop = 1'b0, guitar_seen = 1'b0, halted = 1'b0;

    rec_t        step_recs[$];
    rec_t        expected_recs[$];
    file_byte_t  file_q[$];
    logic [7:0]  body[$];

    int          errors = 0;
    logic        calm = 1'b0;
    int          phase_count = 0;
    logic [7:0]  gen_rs = '0;

    function automatic void post(logic [2:0] k, logic [31:0] t, logic [23:0] v, logic g);
        rec_t r;
        r.kind = k; r.tick = t; r.value = v; r.guitar = g; r.last = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic void clear_parser();
        ph = P_HEAD; pbc = '0; bytes_left = '0; tracks_left = '0; track_idx = '0;
        run_st = '0; cur_st = '0; abs_tick = '0; vacc = '0; meta_id = '0;
        skip_left = '0; first_db = '0; tempo_acc = '0; match_pos = '0;
        name_stop = 1'b0; guitar_seen = 1'b0; halted = 1'b0;
    endfunction

    function automatic void open_tag();
        ph = P_TAG; pbc = '0; abs_tick = '0; run_st = '0; guitar_seen = 1'b0;
    endfunction

    function automatic void next_event();
        ph = P_DELTA; pbc = '0; vacc = '0;
    endfunction

    function automatic void close_track();
        post(KIND_TRACK, abs_tick, {8'h00, track_idx}, guitar_seen);
        track_idx++;
        tracks_left--;
        if (tracks_left == 0) ph = P_DONE;
        else open_tag();
    endfunction

    function automatic void abort_parse();
        post(KIND_ERROR, abs_tick, {8'h00, track_idx}, 1'b0);
        halted = 1'b1;
    endfunction

    // returns 1 on the final byte of a variable-length number
    function automatic logic vlq_take(logic [7:0] b);
        vacc = {vacc[24:0], b[6:0]};
        if (pbc < 4'd15) pbc++;
        return !b[7];
    endfunction

    function automatic void begin_skip(logic [31:0] n);
        if (n == 0) next_event();
        else
        begin
            skip_left = n; ph = P_SKIP;
        end
    endfunction

    function automatic void take_data1(logic [7:0] b);
        first_db = b;
        if (cur_st[7:4] == ST_PROGRAM[7:4] || cur_st[7:4] == ST_PRESSURE[7:4]) next_event();
        else ph = P_DATA2;
    endfunction

    function automatic void take_data2(logic [7:0] b);
        logic is_on;
        is_on = (cur_st[7:4] == ST_NOTE_ON[7:4]);
        if ((is_on || cur_st[7:4] == ST_NOTE_OFF[7:4]) &&
            first_db >= {1'b0, lo_note} && first_db <= {1'b0, hi_note})
            post((is_on && b != 0) ? KIND_NOTE_ON : KIND_NOTE_OFF, abs_tick,
                 {16'h0000, first_db}, 1'b0);
        next_event();
    endfunction

    function automatic void track_byte(logic [7:0] b);
        logic [31:0] n;
        case (ph)
            P_DELTA:
                if (vlq_take(b))
                begin
                    abs_tick += vacc;
                    vacc = '0; pbc = '0; ph = P_STATUS;
                end
            P_STATUS:
                if (b[7])
                begin
                    cur_st = b;
                    run_st = (b >= ST_SYSEX) ? 8'h00 : b;
                    if (b == ST_META) ph = P_META_TYPE;
                    else if (b == ST_SYSEX || b == ST_SYSEX_ESC)
                    begin
                        ph = P_SYSEX_LEN; vacc = '0; pbc = '0;
                    end
                    else ph = P_DATA1;
                end
                else
                begin
                    cur_st = run_st;
                    take_data1(b);
                end
            P_DATA1: take_data1(b);
            P_DATA2: take_data2(b);
            P_META_TYPE:
            begin
                meta_id = b; ph = P_META_LEN; vacc = '0; pbc = '0;
            end
            P_META_LEN:
                if (vlq_take(b))
                begin
                    n = vacc; vacc = '0; pbc = '0;
                    if (meta_id == META_NAME && n < NAME_LIMIT)
                    begin
                        if (n == 0) next_event();
                        else
                        begin
                            skip_left = n; match_pos = '0; name_stop = 1'b0; ph = P_NAME;
                        end
                    end
                    else if (meta_id == META_TEMPO && n == 3)
                    begin
                        tempo_acc = '0; ph = P_TEMPO;
                    end
                    else begin_skip(n);
                end
            P_SYSEX_LEN:
                if (vlq_take(b))
                begin
                    n = vacc; vacc = '0; pbc = '0;
                    begin_skip(n);
                end
            P_NAME:
            begin
                // substring scan, restarting on a mismatch; NUL ends the name
                if (!name_stop)
                begin
                    if (b == 0) name_stop = 1'b1;
                    else if (match_pos < PAT_LEN && b == GUITAR_TXT[match_pos])
                    begin
                        match_pos++;
                        if (match_pos >= PAT_LEN)
                        begin
                            guitar_seen = 1'b1; match_pos = '0;
                        end
                    end
                    else match_pos = (b == GUITAR_TXT[0]) ? 4'd1 : 4'd0;
                end
                skip_left--;
                if (skip_left == 0) next_event();
            end
            P_TEMPO:
            begin
                tempo_acc = {tempo_acc[15:0], b};
                pbc++;
                if (pbc >= 3)
                begin
                    post(KIND_TEMPO, abs_tick, tempo_acc, 1'b0);
                    next_event();
                end
            end
            default:
            begin
                skip_left--;
                if (skip_left == 0) next_event();
            end
        endcase
    endfunction

    // predicts the records for one accepted byte
    function automatic void predict_byte(logic [7:0] b, logic sof);
        step_recs.delete();
        if (sof) clear_parser();
        if (!halted)
        begin
            case (ph)
                P_HEAD:
                begin
                    if (pbc == 10 || pbc == 11) tracks_left = {tracks_left[7:0], b};
                    else if (pbc == 12) vacc = {24'h0, b};
                    if (pbc == 13)
                    begin
                        post(KIND_DIVISION, 32'h0, {8'h00, vacc[7:0], b}, 1'b0);
                        vacc = '0;
                        if (tracks_left == 0) ph = P_DONE;
                        else open_tag();
                    end
                    else pbc++;
                end
                P_TAG:
                    if (b != CHUNK_TXT[pbc[1:0]]) abort_parse();
                    else
                    begin
                        pbc++;
                        if (pbc >= 4)
                        begin
                            ph = P_LEN; pbc = '0; bytes_left = '0;
                        end
                    end
                P_LEN:
                begin
                    bytes_left = {bytes_left[23:0], b};
                    pbc++;
                    if (pbc >= 4)
                    begin
                        abs_tick = '0; run_st = '0; guitar_seen = 1'b0;
                        next_event();
                        if (bytes_left == 0) close_track();
                    end
                end
                P_DONE: ;
                default:
                begin
                    bytes_left--;
                    track_byte(b);
                    if (bytes_left == 0)
                    begin
                        if (ph == P_DELTA && pbc == 0) close_track();
                        else abort_parse();
                    end
                end
            endcase
        end
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
        foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
    endfunction

    // ------------------------------------------------------------------
    // File generator
    // ------------------------------------------------------------------
    function automatic void push_file_byte(logic [7:0] b, logic sof);
        file_byte_t fb;
        fb.b = b; fb.sof = sof;
        file_q.push_back(fb);
        phase_count++;
    endfunction

    function automatic void put_vlq(int unsigned v);
        logic [7:0] grp[$];
        grp.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0)
        begin
            grp.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        foreach (grp[i]) body.push_back(grp[i]);
    endfunction

    function automatic void put_delta();
        int r;
        r = $urandom_range(0, 11);
        if (r <= 6) put_vlq($urandom_range(0, 127));
        else if (r <= 8) put_vlq($urandom_range(128, 16383));
        else if (r == 9) put_vlq($urandom);
        else if (r == 10)
        begin
            // redundant leading continuation bytes
            body.push_back(8'h80); body.push_back(8'h80); put_vlq($urandom_range(0, 127));
        end
        else
        begin
            // five-byte value wraps the accumulator
            body.push_back(8'h8F); body.push_back(8'hFF); body.push_back(8'hFF);
            body.push_back(8'hFF); body.push_back(8'($urandom_range(0, 127)));
        end
    endfunction

    function automatic void put_note();
        logic       explicit_st;
        int         n;
        logic [7:0] st;
        explicit_st = (gen_rs == 0) || ($urandom_range(0, 2) == 0);
        if (explicit_st)
        begin
            st = 8'(($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF) | $urandom_range(0, 15));
            body.push_back(st);
            gen_rs = st;
        end
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 127);
        else n = int'(lo_note) - 3 + $urandom_range(0, int'(hi_note) - int'(lo_note) + 6);
        if (n < 0) n = 0;
        if (n > 127) n = 127;
        if (explicit_st && $urandom_range(0, 15) == 0) n = n | 128;
        body.push_back(n[7:0]);
        if ($urandom_range(0, 3) == 0) body.push_back(8'h00);
        else if (explicit_st && $urandom_range(0, 15) == 0)
            body.push_back(8'($urandom_range(0, 255)));
        else body.push_back(8'($urandom_range(1, 127)));
    endfunction

    function automatic void put_name();
        int n, at;
        int r;
        logic [7:0] txt[$];
        r = $urandom_range(0, 29);
        n = (r == 0) ? $urandom_range(255, 270) : (r == 1) ? 0 : $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0) txt.push_back(8'h00);
            else if (r <= 2) txt.push_back(GUITAR_TXT[0]);
            else txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        if (n >= PAT_LEN && $urandom_range(0, 1))
        begin
            at = $urandom_range(0, n - PAT_LEN);
            for (int i = 0; i < PAT_LEN; i++) txt[at + i] = GUITAR_TXT[i];
            // sometimes damage one letter so the match just fails
            if ($urandom_range(0, 3) == 0) txt[at + $urandom_range(1, PAT_LEN - 1)] = 8'h58;
        end
        body.push_back(ST_META); body.push_back(META_NAME);
        put_vlq(n);
        foreach (txt[i]) body.push_back(txt[i]);
    endfunction

    function automatic void put_event();
        int r, n;
        put_delta();
        r = $urandom_range(0, 19);
        if (r <= 6 || r >= 18) put_note();
        else if (r == 7)
        begin
            gen_rs = 8'(($urandom_range(0, 1) ? ST_PROGRAM : ST_PRESSURE) |
                        $urandom_range(0, 15));
            body.push_back(gen_rs); body.push_back(8'($urandom_range(0, 127)));
        end
        else if (r == 8)
        begin
            gen_rs = {$urandom_range(0, 1) ? 4'hA : 4'hE, 4'($urandom_range(0, 15))};
            body.push_back(gen_rs);
            body.push_back(8'($urandom_range(0, 127)));
            body.push_back(8'($urandom_range(0, 127)));
        end
        else if (r <= 10)
        begin
            gen_rs = '0;
            body.push_back(ST_META); body.push_back(META_TEMPO); body.push_back(8'h03);
            repeat (3) body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r == 11)
        begin
            gen_rs = '0;
            n = $urandom_range(0, 5);
            if (n == 3) n = 4;
            body.push_back(ST_META); body.push_back(META_TEMPO); put_vlq(n);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r <= 13)
        begin
            gen_rs = '0;
            put_name();
        end
        else if (r == 14)
        begin
            gen_rs = '0;
            n = $urandom_range(0, 6);
            body.push_back(ST_META); body.push_back(8'($urandom_range(0, 255))); put_vlq(n);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r == 15)
        begin
            gen_rs = '0;
            n = $urandom_range(0, 8);
            body.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC); put_vlq(n);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r == 16)
        begin
            // system status: two data bytes, nothing reported
            gen_rs = '0;
            n = $urandom_range(0, 12);
            body.push_back(8'(n < 6 ? 8'hF1 + n : 8'hF8 + n - 6));
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (gen_rs == 0)
            begin
                body.push_back(8'($urandom_range(0, 127)));
                body.push_back(8'($urandom_range(0, 255)));
            end
            else put_note();
        end
    endfunction

    function automatic void put_track(int shape);
        int unsigned len;
        int bad;
        body.delete();
        gen_rs = '0;
        if (shape != 3)
        begin
            repeat ($urandom_range(0, 10)) put_event();
            put_delta(); body.push_back(ST_META); body.push_back(META_EOT); body.push_back(8'h00);
        end
        len = body.size();
        if (shape == 1) len = len - $urandom_range(1, (len < 6) ? len : 6);
        else if (shape == 2) len = len + $urandom_range(1, 3);
        bad = (shape == 0) ? $urandom_range(0, 3) : -1;
        for (int i = 0; i < 4; i++)
            push_file_byte(i == bad ? 8'(CHUNK_TXT[i] ^ $urandom_range(1, 255))
                                    : CHUNK_TXT[i], 1'b0);
        for (int i = 3; i >= 0; i--) push_file_byte(len[8*i +: 8], 1'b0);
        foreach (body[i]) push_file_byte(body[i], 1'b0);
    endfunction

    function automatic void put_file();
        int r, ntr, nbuilt;
        r = $urandom_range(0, 11);
        if (r == 0)
        begin
            // noise from the first byte on
            push_file_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(10, 30)) push_file_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        ntr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        push_file_byte(8'h4D, 1'b1);
        push_file_byte(8'h54, 1'b0); push_file_byte(8'h68, 1'b0); push_file_byte(8'h64, 1'b0);
        push_file_byte(8'h00, 1'b0); push_file_byte(8'h00, 1'b0);
        push_file_byte(8'h00, 1'b0); push_file_byte(8'h06, 1'b0);
        push_file_byte(8'($urandom_range(0, 255)), 1'b0);
        push_file_byte(8'($urandom_range(0, 255)), 1'b0);
        if (r == 1) push_file_byte(8'($urandom_range(1, 255)), 1'b0);
        else push_file_byte(8'h00, 1'b0);
        push_file_byte(ntr[7:0], 1'b0);
        push_file_byte(8'($urandom_range(0, 255)), 1'b0);
        push_file_byte(8'($urandom_range(0, 255)), 1'b0);
        nbuilt = (r == 2) ? ntr + 1 : ntr;
        for (int t = 0; t < nbuilt; t++)
        begin
            r = $urandom_range(0, 19);
            put_track(r <= 3 ? r : 9);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) push_file_byte(8'($urandom_range(0, 255)), 1'b0);
    endfunction

    // directed file: in-range note on, running-status zero-velocity off, tempo,
    // guitar name, out-of-range note, end of track
    function automatic void put_directed();
        logic [7:0] d[$];
        d = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
              8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'hFF};
        foreach (d[i]) push_file_byte(d[i], i == 0);
        body.delete();
        body = '{8'h00, ST_NOTE_ON, 8'd84, 8'h40, 8'h81, 8'h00, 8'd88, 8'h00,
                 8'h00, ST_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, ST_META, META_NAME, 8'd11};
        for (int i = 0; i < PAT_LEN; i++) body.push_back(GUITAR_TXT[i]);
        body.push_back(8'h7F); body.push_back(ST_NOTE_OFF); body.push_back(8'd89);
        body.push_back(8'h00);
        body.push_back(8'h00); body.push_back(ST_META); body.push_back(META_EOT);
        body.push_back(8'h00);
        for (int i = 0; i < 4; i++) push_file_byte(CHUNK_TXT[i], 1'b0);
        push_file_byte(8'h00, 1'b0); push_file_byte(8'h00, 1'b0);
        push_file_byte(8'h00, 1'b0); push_file_byte(8'(body.size()), 1'b0);
        foreach (body[i]) push_file_byte(body[i], 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    file_byte_t held;
    int         send_gap = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) predict_byte(held.b, held.sof);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (file_q.size() > 0)
                begin
                    held = file_q.pop_front();
                    data_byte <= held.b;
                    start_of_file <= held.sof;
                    in_valid <= 1'b1;
                    send_gap = calm ? 0 : $urandom_range(0, 13);
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int   recv_wait = 0;
    rec_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_recs.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"unexpected record: kind %0d tick %0d value %0d",
                                  " guitar %0d last %0d"},
                                 kind, tick, value, guitar_track, last_of_run);
                end
                else
                begin
                    want = expected_recs.pop_front();
                    if (kind !== want.kind || tick !== want.tick || value !== want.value ||
                        guitar_track !== want.guitar || last_of_run !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"record mismatch: exp kind %0d tick %0d value %0d",
                                      " g %0d last %0d, got kind %0d tick %0d value %0d",
                                      " g %0d last %0d"},
                                     want.kind, want.tick, want.value, want.guitar, want.last,
                                     kind, tick, value, guitar_track, last_of_run);
                    end
                end
                recv_wait = calm ? 0 : $urandom_range(0, 13);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, then per note range the config writes and a batch
    // ------------------------------------------------------------------
    task automatic write_reg(logic [0:0] idx, logic [6:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_LOWEST) lo_note = d;
        else hi_note = d;
        cfg_valid <= 1'b0;
    endtask

    // waits until every queued byte is sent and every expected record has come back; sampled
    // mid-cycle so the driver's updates at the edge are settled
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((file_q.size() != 0 || in_valid || expected_recs.size() != 0) && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [6:0] l, h;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: begin l = 7'd84;  h = 7'd88;  end
                1: begin l = 7'd0;   h = 7'd127; end
                2: begin l = 7'd0;   h = 7'd0;   end
                3: begin l = 7'd127; h = 7'd127; end
                4: begin l = 7'd88;  h = 7'd84;  end
                5: begin l = 7'd60;  h = 7'd72;  end
                default:
                begin
                    l = 7'($urandom_range(0, 127));
                    h = 7'($urandom_range(l, 127));
                end
            endcase
            write_reg(REG_LOWEST, l);
            write_reg(REG_HIGHEST, h);
            calm = (p == 2);
            phase_count = 0;
            if (p == 0) put_directed();
            while (phase_count < 60) put_file();
            wait_idle();
        end
        if (expected_recs.size() != 0) errors++;
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
